// ----- rtl/core/bsd_pkg.sv -----
// Shared types and constants for the byte stuffing deframer.
package bsd_pkg;

  localparam logic [7:0] FLAG_BYTE = 8'h41;  // 'A'
  localparam logic [7:0] ESC_BYTE  = 8'h42;  // 'B'
  localparam logic [7:0] ESC_FLAG  = 8'h43;  // 'C'
  localparam logic [7:0] ESC_ESC   = 8'h44;  // 'D'

  localparam int unsigned MAXP_W  = 13;
  localparam int unsigned LEN_W   = 14;
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef struct packed {
    logic             last;
    logic [LEN_W-1:0] frame_length;
    kind_t            kind;
    logic [7:0]       data_byte;
  } res_t;

  // Results caused by one input byte, zero to two of them.
  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } dec_t;

  typedef struct packed {
    logic [Q_CNT_W-1:0] level;
    logic               space;     // room for two more results
    logic               nonempty;
  } q_stat_t;

endpackage

// ----- rtl/core/bsd_decode.sv -----
// Frame state and per-byte unstuffing decision.
module bsd_decode (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic [7:0]                  rx_byte,
  input  logic [bsd_pkg::MAXP_W-1:0]  max_payload,
  output bsd_pkg::dec_t               dec
);

  typedef enum logic [1:0] {
    MODE_HUNT  = 2'd0,
    MODE_FRAME = 2'd1,
    MODE_ESC   = 2'd2
  } mode_t;

  mode_t                      mode, mode_next;
  logic [bsd_pkg::LEN_W-1:0]  raw_count, raw_count_next;
  logic [bsd_pkg::LEN_W-1:0]  payload_count, payload_count_next;

  logic [bsd_pkg::LEN_W:0]    raw_inc;
  logic [bsd_pkg::LEN_W-1:0]  limit;
  logic [bsd_pkg::LEN_W-1:0]  pay_base;
  bsd_pkg::res_t              esc_res, byte_res;
  logic                       byte_has_res;
  logic                       pending;

  assign raw_inc = {1'b0, raw_count} + (bsd_pkg::LEN_W + 1)'(1);
  assign limit   = {max_payload, 1'b0};
  assign pending = (mode == MODE_ESC);

  always_comb begin
    mode_next          = mode;
    raw_count_next     = raw_count;
    payload_count_next = payload_count;
    dec                = '0;
    esc_res            = '0;
    byte_res           = '0;
    byte_has_res       = 1'b0;
    pay_base           = payload_count;
    unique case (mode)
      MODE_FRAME, MODE_ESC: begin
        if (raw_inc > {1'b0, limit}) begin
          dec.count          = 2'd1;
          dec.r0.kind        = bsd_pkg::KIND_ERROR;
          dec.r0.last        = 1'b1;
          mode_next          = MODE_HUNT;
          raw_count_next     = '0;
          payload_count_next = '0;
        end else begin
          raw_count_next = raw_inc[bsd_pkg::LEN_W-1:0];
          mode_next      = MODE_FRAME;
          if (pending && (rx_byte == bsd_pkg::ESC_FLAG || rx_byte == bsd_pkg::ESC_ESC)) begin
            dec.count           = 2'd1;
            dec.r0.kind         = bsd_pkg::KIND_DATA;
            dec.r0.data_byte    = (rx_byte == bsd_pkg::ESC_FLAG) ? bsd_pkg::FLAG_BYTE
                                                                 : bsd_pkg::ESC_BYTE;
            dec.r0.last         = 1'b1;
            payload_count_next  = payload_count + bsd_pkg::LEN_W'(1);
          end else begin
            // a stale escape passes through as a plain 'B' first
            esc_res.kind      = bsd_pkg::KIND_DATA;
            esc_res.data_byte = bsd_pkg::ESC_BYTE;
            if (pending) begin
              pay_base = payload_count + bsd_pkg::LEN_W'(1);
            end
            payload_count_next = pay_base;
            priority if (rx_byte == bsd_pkg::FLAG_BYTE) begin
              byte_res.kind         = bsd_pkg::KIND_END;
              byte_res.frame_length = pay_base;
              byte_has_res          = 1'b1;
              mode_next             = MODE_HUNT;
              raw_count_next        = '0;
              payload_count_next    = '0;
            end else if (rx_byte == bsd_pkg::ESC_BYTE) begin
              mode_next = MODE_ESC;
            end else begin
              byte_res.kind      = bsd_pkg::KIND_DATA;
              byte_res.data_byte = rx_byte;
              byte_has_res       = 1'b1;
              payload_count_next = pay_base + bsd_pkg::LEN_W'(1);
            end
            if (pending) begin
              dec.r0 = esc_res;
              dec.r1 = byte_res;
              if (byte_has_res) begin
                dec.count   = 2'd2;
                dec.r1.last = 1'b1;
              end else begin
                dec.count   = 2'd1;
                dec.r0.last = 1'b1;
              end
            end else begin
              dec.r0 = byte_res;
              if (byte_has_res) begin
                dec.count   = 2'd1;
                dec.r0.last = 1'b1;
              end
            end
          end
        end
      end
      default: begin
        mode_next = MODE_HUNT;
        if (rx_byte == bsd_pkg::FLAG_BYTE) begin
          mode_next          = MODE_FRAME;
          raw_count_next     = '0;
          payload_count_next = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_HUNT;
      raw_count     <= '0;
      payload_count <= '0;
    end else if (advance) begin
      mode          <= mode_next;
      raw_count     <= raw_count_next;
      payload_count <= payload_count_next;
    end
  end

endmodule

// ----- rtl/core/bsd_resq.sv -----
// Small result queue: takes up to two results a cycle, hands out one.
module bsd_resq (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bsd_pkg::dec_t    dec,
  input  logic             pop,
  output bsd_pkg::res_t    head,
  output bsd_pkg::q_stat_t stat
);

  bsd_pkg::res_t                  mem [bsd_pkg::Q_DEPTH];
  logic [bsd_pkg::Q_PTR_W-1:0]    wr_ptr, rd_ptr;
  logic [bsd_pkg::Q_CNT_W-1:0]    level, level_next;
  logic [bsd_pkg::Q_PTR_W-1:0]    wr_ptr_inc;
  logic [1:0]                     n_push;

  assign n_push     = push ? dec.count : 2'd0;
  assign wr_ptr_inc = wr_ptr + bsd_pkg::Q_PTR_W'(1);
  assign level_next = level + bsd_pkg::Q_CNT_W'(n_push) - bsd_pkg::Q_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem[wr_ptr] <= dec.r0;
    end
    if (n_push == 2'd2) begin
      mem[wr_ptr_inc] <= dec.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + bsd_pkg::Q_PTR_W'(n_push);
      rd_ptr <= rd_ptr + bsd_pkg::Q_PTR_W'(pop);
      level  <= level_next;
    end
  end

  assign head           = mem[rd_ptr];
  assign stat.level     = level;
  assign stat.space     = (level <= bsd_pkg::Q_CNT_W'(bsd_pkg::Q_DEPTH - 2));
  assign stat.nonempty  = (level != '0);

endmodule

// ----- rtl/core/byte_stuffing_deframer_top.sv -----
// Top level of the byte stuffing deframer.
//
//  channel | dir | handshake         | payload
//  s_*     | in  | s_tvalid/s_tready | tdata[7:0] rx_byte
//  m_*     | out | m_tvalid/m_tready | tdata data_byte, frame_length; tuser kind; tlast last
//  cfg_*   | in  | cfg_wen           | cfg_wdata max_payload
//
// One byte a cycle while the queue has room: a request lands in the input register,
// is decoded from there and its zero to two results go into a four-entry queue.
// A byte is decoded only when the queue has room for two results; a byte that
// makes two results takes two output transfers, which is what bounds throughput.
// Reset (synchronous) restores hunting mode, zero counts and max_payload 1000.
// A stall on m_tready fills the queue and then holds s_tready low.
module byte_stuffing_deframer_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,    // [7:0] rx_byte
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [23:0]                m_tdata,    // [7:0] data_byte, [21:8] frame_length, 0 pad
  output logic [1:0]                 m_tuser,    // [1:0] kind
  output logic                       m_tlast,
  input  logic                       cfg_wen,
  input  logic [bsd_pkg::MAXP_W-1:0] cfg_wdata
);

  logic                       in_valid;
  logic [7:0]                 in_byte;
  logic                       advance;
  logic [bsd_pkg::MAXP_W-1:0] max_payload;
  bsd_pkg::dec_t              dec;
  bsd_pkg::res_t              head;
  bsd_pkg::q_stat_t           stat;
  logic                       pop;

  assign advance  = in_valid && stat.space;
  assign s_tready = !in_valid || advance;
  assign pop      = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      max_payload <= bsd_pkg::MAXP_W'(1000);
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (cfg_wen) begin
        max_payload <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  bsd_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .rx_byte     (in_byte),
    .max_payload (max_payload),
    .dec         (dec)
  );

  bsd_resq u_resq (
    .clk  (clk),
    .rst  (rst),
    .push (advance),
    .dec  (dec),
    .pop  (pop),
    .head (head),
    .stat (stat)
  );

  assign m_tvalid = stat.nonempty;
  assign m_tdata  = {2'b00, head.frame_length, head.data_byte};
  assign m_tuser  = head.kind;
  assign m_tlast  = head.last;

  // queue never overfills
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    stat.level <= bsd_pkg::Q_CNT_W'(bsd_pkg::Q_DEPTH))
    else $error("result queue level out of range");

  // a decoded byte that yields nothing cannot grow the queue
  a_no_result_no_growth: assert property (@(posedge clk) disable iff (rst)
    (advance && dec.count == 2'd0) |=> stat.level <= $past(stat.level))
    else $error("queue grew without results");

  // of a byte with two results, only the second one carries tlast
  a_pair_last: assert property (@(posedge clk) disable iff (rst)
    (advance && dec.count == 2'd2) |-> (dec.r1.last && !dec.r0.last))
    else $error("two-result request marked wrong");

  // an error result only ever comes alone
  a_error_alone: assert property (@(posedge clk) disable iff (rst)
    (advance && dec.r0.kind == bsd_pkg::KIND_ERROR && dec.count != 2'd0)
      |-> dec.count == 2'd1)
    else $error("overflow error paired with another result");

endmodule

// ----- dv/tb_byte_stuffing_deframer_top.sv -----
// Self-checking testbench for the byte stuffing deframer: directed and random frames.
`timescale 1ns / 100ps

module tb_byte_stuffing_deframer_top;

  localparam int SETTLE_CYCLES  = 8;     // input register + decode + queue, with margin
  localparam int STALL_LIMIT    = 1000;  // cycles without any byte, result or setting moving

  typedef enum logic [1:0] {
    MODE_HUNT  = 2'd0,
    MODE_FRAME = 2'd1,
    MODE_ESC   = 2'd2
  } rx_mode_t;

  typedef logic [7:0] byte_list_t[$];

  class deframer_predictor;
    rx_mode_t                   mode;
    int unsigned                raw_count;
    logic [bsd_pkg::LEN_W-1:0]  payload_count;
    logic [bsd_pkg::MAXP_W-1:0] max_payload;
    bsd_pkg::res_t              pending_results[$];
    int                         errors;
    int                         kind_seen[3];

    function new();
      mode          = MODE_HUNT;
      raw_count     = 0;
      payload_count = '0;
      max_payload   = 13'd1000;
      errors        = 0;
      kind_seen     = '{0, 0, 0};
    endfunction

    function void set_max_payload(logic [bsd_pkg::MAXP_W-1:0] value);
      max_payload = value;
    endfunction

    function bsd_pkg::res_t make_result(logic [7:0] data, bsd_pkg::kind_t kind,
                                        logic [bsd_pkg::LEN_W-1:0] len);
      bsd_pkg::res_t r;
      r              = '0;
      r.data_byte    = data;
      r.kind         = kind;
      r.frame_length = len;
      return r;
    endfunction

    function bsd_pkg::res_t emit_data(logic [7:0] data);
      payload_count = payload_count + 1'b1;
      return make_result(data, bsd_pkg::KIND_DATA, '0);
    endfunction

    function void note_byte(logic [7:0] b);
      bsd_pkg::res_t batch[$];
      int unsigned   limit;
      bit            handled;
      limit   = 2 * max_payload;
      handled = 0;
      if (mode != MODE_FRAME && mode != MODE_ESC) begin
        mode = MODE_HUNT;
        if (b == bsd_pkg::FLAG_BYTE) begin
          mode          = MODE_FRAME;
          raw_count     = 0;
          payload_count = '0;
        end
      end else begin
        raw_count++;
        // overflow wins over decoding; a pending escape is dropped
        if (raw_count > limit) begin
          batch.push_back(make_result(8'h00, bsd_pkg::KIND_ERROR, '0));
          mode          = MODE_HUNT;
          raw_count     = 0;
          payload_count = '0;
        end else begin
          raw_count &= 32'h3fff;
          if (mode == MODE_ESC) begin
            mode = MODE_FRAME;
            if (b == bsd_pkg::ESC_FLAG) begin
              batch.push_back(emit_data(bsd_pkg::FLAG_BYTE));
              handled = 1;
            end else if (b == bsd_pkg::ESC_ESC) begin
              batch.push_back(emit_data(bsd_pkg::ESC_BYTE));
              handled = 1;
            end else begin
              batch.push_back(emit_data(bsd_pkg::ESC_BYTE));
            end
          end
          if (!handled) begin
            if (b == bsd_pkg::FLAG_BYTE) begin
              batch.push_back(make_result(8'h00, bsd_pkg::KIND_END, payload_count));
              mode          = MODE_HUNT;
              raw_count     = 0;
              payload_count = '0;
            end else if (b == bsd_pkg::ESC_BYTE) begin
              mode = MODE_ESC;
            end else begin
              batch.push_back(emit_data(b));
            end
          end
        end
      end
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[i]) pending_results.push_back(batch[i]);
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      end
    endfunction

    function void check_result(bsd_pkg::res_t got);
      bsd_pkg::res_t exp_r;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual kind %0d data %0d len %0d",
                 $time, got.kind, got.data_byte, got.frame_length);
      end else begin
        exp_r = pending_results.pop_front();
        compare_field("data_byte", exp_r.data_byte, got.data_byte);
        compare_field("kind", exp_r.kind, got.kind);
        compare_field("frame_length", exp_r.frame_length, got.frame_length);
        compare_field("last", exp_r.last, got.last);
        if (exp_r.kind <= bsd_pkg::KIND_ERROR) kind_seen[exp_r.kind]++;
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       s_tvalid;
  logic                       s_tready;
  logic [7:0]                 s_tdata;    // [7:0] rx_byte
  logic                       m_tvalid;
  logic                       m_tready;
  logic [23:0]                m_tdata;    // [7:0] data_byte, [21:8] frame_length, 0 pad
  logic [1:0]                 m_tuser;    // [1:0] kind
  logic                       m_tlast;
  logic                       cfg_wen;
  logic [bsd_pkg::MAXP_W-1:0] cfg_wdata;

  deframer_predictor predictor = new();

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int phase_bytes;
  int bytes_sent = 0;
  int settings_written = 0;
  int quiet_cycles = 0;

  byte_stuffing_deframer_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (receiver_stall_pct == 0) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // results are sampled before this edge's updates land
  always @(posedge clk) begin
    bsd_pkg::res_t got;
    if (!rst && m_tvalid && m_tready) begin
      got              = '0;
      got.data_byte    = m_tdata[7:0];
      got.frame_length = m_tdata[21:8];
      got.kind         = bsd_pkg::kind_t'(m_tuser);
      got.last         = m_tlast;
      predictor.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding", $time,
               STALL_LIMIT, predictor.pending_results.size());
      $display("tb_byte_stuffing_deframer_top failed");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (s_tready !== 1'b1);
    predictor.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_list(byte_list_t list);
    foreach (list[i]) send_byte(list[i]);
  endtask

  task automatic send_frame_byte(logic [7:0] b);
    send_byte(b);
    phase_bytes++;
  endtask

  task automatic wait_for_results;
    s_tvalid <= 1'b0;
    while (predictor.pending_results.size() != 0) @(posedge clk);
  endtask

  // bytes that make no result may still be in flight once the queue is empty
  task automatic wait_for_idle;
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_payload(logic [bsd_pkg::MAXP_W-1:0] value);
    wait_for_idle();
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    predictor.set_max_payload(value);
    settings_written++;
  endtask

  // one frame with random content, sometimes sized around the overflow limit
  task automatic send_frame(int max_payload);
    int body;
    int k;
    int r;
    repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
    if (max_payload <= 20 && $urandom_range(0, 9) < 3) begin
      body = 2 * max_payload - 2 + $urandom_range(0, 4);
    end else begin
      body = $urandom_range(0, 12);
    end
    send_frame_byte(bsd_pkg::FLAG_BYTE);
    k = 0;
    while (k < body) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        send_frame_byte(8'($urandom_range(0, 255)));
        k++;
      end else if (r < 56) begin
        send_frame_byte($urandom_range(0, 1) ? bsd_pkg::ESC_FLAG : bsd_pkg::ESC_ESC);
        k++;
      end else if (r < 96) begin
        send_frame_byte(bsd_pkg::ESC_BYTE);
        if (r < 70) begin
          send_frame_byte(bsd_pkg::ESC_FLAG);
        end else if (r < 82) begin
          send_frame_byte(bsd_pkg::ESC_ESC);
        end else if (r < 90) begin
          send_frame_byte(8'($urandom_range(0, 255)));
        end else begin
          send_frame_byte(bsd_pkg::ESC_BYTE);
        end
        k += 2;
      end else begin
        send_frame_byte(bsd_pkg::FLAG_BYTE);  // early close, the rest lands while hunting
        k++;
      end
    end
    if ($urandom_range(0, 9) != 0) send_frame_byte(bsd_pkg::FLAG_BYTE);
  endtask

  task automatic run_phase(int max_payload, int send_idle, int recv_stall, int n_bytes,
                           bit long_frame);
    logic [7:0] b;
    bit         paused;
    write_max_payload(max_payload[bsd_pkg::MAXP_W-1:0]);
    sender_idle_pct    = send_idle;
    receiver_stall_pct = recv_stall;
    if (long_frame) begin
      // longest payload that still closes under the current limit, no flag or escape
      send_byte(bsd_pkg::FLAG_BYTE);
      repeat (2 * max_payload - 1) begin
        b = 8'($urandom_range(0, 255));
        if (b == bsd_pkg::FLAG_BYTE || b == bsd_pkg::ESC_BYTE) b = b ^ 8'h80;
        send_byte(b);
      end
      send_byte(bsd_pkg::FLAG_BYTE);
    end
    phase_bytes = 0;
    paused      = 0;
    while (phase_bytes < n_bytes) begin
      if (!paused && phase_bytes >= n_bytes / 2) begin
        wait_for_results();
        paused = 1;
      end
      send_frame(max_payload);
    end
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_wen   = 1'b0;
    cfg_wdata = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // hunting drops everything but the flag; empty frame; closing flag opens nothing
    send_list('{8'h00, 8'hFF, bsd_pkg::ESC_BYTE, bsd_pkg::FLAG_BYTE, bsd_pkg::FLAG_BYTE,
                8'h33});
    // escapes, escape before a plain byte, escape before escape, escape before close
    send_list('{bsd_pkg::FLAG_BYTE, bsd_pkg::ESC_BYTE, bsd_pkg::ESC_FLAG, bsd_pkg::ESC_BYTE,
                bsd_pkg::ESC_ESC, bsd_pkg::ESC_BYTE, 8'hFF, bsd_pkg::ESC_BYTE,
                bsd_pkg::ESC_BYTE, bsd_pkg::ESC_ESC, bsd_pkg::ESC_BYTE, bsd_pkg::FLAG_BYTE});
    // zero limit: first byte inside a frame overflows
    write_max_payload('0);
    send_list('{bsd_pkg::FLAG_BYTE, 8'h55});
    // limit 2: closing flag right at the limit, then overflow dropping a pending escape
    write_max_payload(13'd1);
    send_list('{bsd_pkg::FLAG_BYTE, 8'h10, bsd_pkg::FLAG_BYTE, bsd_pkg::FLAG_BYTE, 8'h01,
                bsd_pkg::ESC_BYTE, bsd_pkg::FLAG_BYTE});

    run_phase(1, 0, 0, 200, 1'b0);
    run_phase(4096, 66, 0, 300, 1'b0);
    run_phase(3, 0, 66, 300, 1'b0);
    run_phase(7, 27, 27, 300, 1'b0);
    run_phase($urandom_range(1, 20), 66, 0, 300, 1'b0);
    run_phase(1000, 27, 27, 300, 1'b0);
    run_phase(150, 0, 0, 100, 1'b1);

    wait_for_idle();
    $display("Covered %0d input bytes under %0d max_payload settings.", bytes_sent,
             settings_written);
    $display("Checked %0d data, %0d end-of-frame and %0d overflow results; %0d errors.",
             predictor.kind_seen[bsd_pkg::KIND_DATA], predictor.kind_seen[bsd_pkg::KIND_END],
             predictor.kind_seen[bsd_pkg::KIND_ERROR], predictor.errors);
    if (predictor.errors == 0) begin
      $display("tb_byte_stuffing_deframer_top passed");
    end else begin
      $display("tb_byte_stuffing_deframer_top failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/bsd_pkg.sv
rtl/core/bsd_decode.sv
rtl/core/bsd_resq.sv
rtl/core/byte_stuffing_deframer_top.sv
dv/tb_byte_stuffing_deframer_top.sv
